[hdl/rcam_pkg.sv]
`timescale 1ns / 1ps

package rcam_pkg;

    // Largest frame dimension the counters cover.
    localparam int MAX_DIM = 4096;

    // Configuration register and counter widths.
    localparam int DIM_W     = 13;
    localparam int CNT_W     = 12;
    localparam int COLOR_W   = 8;
    localparam int SQ_W      = 2 * CNT_W;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS = 2'd2;

    // Frame geometry after clamping, as seen by the pixel pipeline.
    typedef struct packed {
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [CNT_W-1:0] r;
        logic [SQ_W-1:0]  rr;
    } rcam_geom_t;

    // One RGBA pixel.
    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] alpha;
    } rcam_rgba_t;

    // Per-axis corner band test result.
    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] d;
    } rcam_offset_t;

endpackage

[hdl/rcam_pixel_if.sv]
`timescale 1ns / 1ps

interface rcam_pixel_if import rcam_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
    logic               frame_start;

    modport source (
        output valid,
        input  ready,
        output red,
        output green,
        output blue,
        output alpha,
        output frame_start
    );

    modport sink (
        input  valid,
        output ready,
        input  red,
        input  green,
        input  blue,
        input  alpha,
        input  frame_start
    );

endinterface

[hdl/rcam_result_if.sv]
`timescale 1ns / 1ps

interface rcam_result_if import rcam_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic [COLOR_W-1:0] alpha_out;
    logic               frame_end;

    modport source (
        output valid,
        input  ready,
        output red_out,
        output green_out,
        output blue_out,
        output alpha_out,
        output frame_end
    );

    modport sink (
        input  valid,
        output ready,
        input  red_out,
        input  green_out,
        input  blue_out,
        input  alpha_out,
        input  frame_end
    );

endinterface

[hdl/rounded_corner_alpha_mask_core.sv]
// Channel      Direction  Content
// pixel_in     in         red, green, blue, alpha, frame_start
// pixel_out    out        red_out, green_out, blue_out, alpha_out, frame_end
// cfg_*        in         write enable, register index, 13-bit data
//
// One pixel per clock sustained while the result is taken; a request's result passes
// through the input, position, offset, square and output stage registers.
// The two squarers in the square stage set the longest path.
// Reset puts the counters at the origin, width and height at 1 and radius at 0.
// Each stage holds while its successor is full and stalled, so pixel_in.ready falls only
// when all five stages are occupied and the result is not taken.
`timescale 1ns / 1ps

module rounded_corner_alpha_mask_core import rcam_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    rcam_pixel_if.sink           pixel_in,
    rcam_result_if.source        pixel_out,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    rcam_geom_t geom;

    // Stage enables.
    logic en1, en2, en3, en4, en5;

    // Input stage.
    logic       s1_valid_reg;
    rcam_rgba_t s1_pix_reg;
    logic       s1_fs_reg;

    // Position stage and pixel counters.
    logic             s2_valid_reg;
    rcam_rgba_t       s2_pix_reg;
    logic [CNT_W-1:0] s2_x_reg;
    logic [CNT_W-1:0] s2_y_reg;
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;
    logic [CNT_W-1:0] x_cur;
    logic [CNT_W-1:0] y_cur;
    logic [DIM_W-1:0] x_inc;
    logic [DIM_W-1:0] y_inc;

    // Offset stage.
    logic             s3_valid_reg;
    rcam_rgba_t       s3_pix_reg;
    logic             s3_hit_reg;
    logic             s3_end_reg;
    logic [CNT_W-1:0] s3_dx_reg;
    logic [CNT_W-1:0] s3_dy_reg;
    rcam_offset_t     off_x;
    rcam_offset_t     off_y;
    logic             hit_next;
    logic             end_next;

    // Square stage.
    logic            s4_valid_reg;
    rcam_rgba_t      s4_pix_reg;
    logic            s4_hit_reg;
    logic            s4_end_reg;
    logic [SQ_W-1:0] s4_sqx_reg;
    logic [SQ_W-1:0] s4_sqy_reg;

    // Output stage.
    logic            out_valid_reg;
    rcam_rgba_t      out_pix_reg;
    logic            out_end_reg;
    logic [SQ_W:0]   dist_sum;
    logic            outside;

    // Corner band test along one axis: distance from the corner center.
    function automatic rcam_offset_t corner_offset(
        input logic [CNT_W-1:0] pos,
        input logic [DIM_W-1:0] size,
        input logic [CNT_W-1:0] r
    );
        logic [DIM_W-1:0] band_start;
        logic [DIM_W-1:0] diff;
        rcam_offset_t     res;
        band_start = size - {1'b0, r};
        diff       = {1'b0, pos} - band_start;
        res.hit    = 1'b0;
        res.d      = '0;
        if (pos < r)
        begin
            res.hit = 1'b1;
            res.d   = r - CNT_W'(1) - pos;
        end
        else if ({1'b0, pos} >= band_start)
        begin
            res.hit = 1'b1;
            res.d   = diff[CNT_W-1:0];
        end
        return res;
    endfunction

    rcam_geometry u_geometry (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    // Each stage loads when it is empty or its content moves on.
    assign en5 = !out_valid_reg || pixel_out.ready;
    assign en4 = !s4_valid_reg || en5;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;
    assign pixel_in.ready = en1;

    // Valid bits of the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= pixel_in.valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
            if (en4)
                s4_valid_reg <= s3_valid_reg;
            if (en5)
                out_valid_reg <= s4_valid_reg;
        end
    end

    // Input register.
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_pix_reg.red   <= pixel_in.red;
            s1_pix_reg.green <= pixel_in.green;
            s1_pix_reg.blue  <= pixel_in.blue;
            s1_pix_reg.alpha <= pixel_in.alpha;
            s1_fs_reg        <= pixel_in.frame_start;
        end
    end

    // Raster position of the pixel and the position of the next one.
    always_comb
    begin
        x_cur    = s1_fs_reg ? '0 : col_reg;
        y_cur    = s1_fs_reg ? '0 : row_reg;
        x_inc    = {1'b0, x_cur} + DIM_W'(1);
        y_inc    = {1'b0, y_cur} + DIM_W'(1);
        col_next = x_inc[CNT_W-1:0];
        row_next = y_cur;
        if (x_inc >= geom.w)
        begin
            col_next = '0;
            row_next = (y_inc >= geom.h) ? '0 : y_inc[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (en2 && s1_valid_reg)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_pix_reg <= s1_pix_reg;
            s2_x_reg   <= x_cur;
            s2_y_reg   <= y_cur;
        end
    end

    // Corner offsets and the end-of-frame flag.
    always_comb
    begin
        off_x    = corner_offset(s2_x_reg, geom.w, geom.r);
        off_y    = corner_offset(s2_y_reg, geom.h, geom.r);
        hit_next = (geom.r != '0) && off_x.hit && off_y.hit;
        end_next = ({1'b0, s2_x_reg} == geom.w - DIM_W'(1))
                && ({1'b0, s2_y_reg} == geom.h - DIM_W'(1));
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_pix_reg <= s2_pix_reg;
            s3_hit_reg <= hit_next;
            s3_end_reg <= end_next;
            s3_dx_reg  <= off_x.d;
            s3_dy_reg  <= off_y.d;
        end
    end

    // Squared offsets.
    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_pix_reg <= s3_pix_reg;
            s4_hit_reg <= s3_hit_reg;
            s4_end_reg <= s3_end_reg;
            s4_sqx_reg <= SQ_W'(s3_dx_reg) * SQ_W'(s3_dx_reg);
            s4_sqy_reg <= SQ_W'(s3_dy_reg) * SQ_W'(s3_dy_reg);
        end
    end

    // Distance compare against the squared radius; clear alpha outside the arc.
    always_comb
    begin
        dist_sum = {1'b0, s4_sqx_reg} + {1'b0, s4_sqy_reg};
        outside  = s4_hit_reg && (dist_sum > {1'b0, geom.rr});
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            out_pix_reg.red   <= s4_pix_reg.red;
            out_pix_reg.green <= s4_pix_reg.green;
            out_pix_reg.blue  <= s4_pix_reg.blue;
            out_pix_reg.alpha <= outside ? '0 : s4_pix_reg.alpha;
            out_end_reg       <= s4_end_reg;
        end
    end

    assign pixel_out.valid     = out_valid_reg;
    assign pixel_out.red_out   = out_pix_reg.red;
    assign pixel_out.green_out = out_pix_reg.green;
    assign pixel_out.blue_out  = out_pix_reg.blue;
    assign pixel_out.alpha_out = out_pix_reg.alpha;
    assign pixel_out.frame_end = out_end_reg;

    // Input back-pressure only when every stage is full and the result is held.
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !pixel_in.ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                             && s4_valid_reg && out_valid_reg && !pixel_out.ready))
        else $error("input stalled while the pipeline has room");

    // A frame start places the pixel at the origin.
    a_frame_origin: assert property (@(posedge clk) disable iff (!rst_n)
        (en2 && s1_valid_reg && s1_fs_reg) |=> (s2_x_reg == '0 && s2_y_reg == '0))
        else $error("frame start pixel not placed at the origin");

    // The column counter either steps by one or wraps to zero.
    a_column_step: assert property (@(posedge clk) disable iff (!rst_n)
        (en2 && s1_valid_reg && !s1_fs_reg)
            |=> (col_reg == $past(col_reg) + CNT_W'(1) || col_reg == '0))
        else $error("column counter moved by other than one step");

endmodule

[hdl/rcam_geometry.sv]
`timescale 1ns / 1ps

module rcam_geometry import rcam_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    output rcam_geom_t           geom
);

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [DIM_W-1:0] radius_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] min_dim;
    logic [CNT_W-1:0] half_dim;
    logic [CNT_W-1:0] r_next;

    logic [DIM_W-1:0] w_reg;
    logic [DIM_W-1:0] h_reg;
    logic [CNT_W-1:0] r_reg;
    logic [SQ_W-1:0]  rr_reg;

    // A zero dimension acts as one, an oversized one as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0)
            res = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            res = DIM_W'(MAX_DIM);
        else
            res = v;
        return res;
    endfunction

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            radius_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IMAGE_WIDTH:   width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT:  height_reg <= cfg_data;
                CFG_CORNER_RADIUS: radius_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Clamp the radius to half the smaller dimension so corners never overlap.
    always_comb
    begin
        w_eff    = eff_dim(width_reg);
        h_eff    = eff_dim(height_reg);
        min_dim  = (w_eff < h_eff) ? w_eff : h_eff;
        half_dim = min_dim[DIM_W-1:1];
        r_next   = (radius_reg < {1'b0, half_dim}) ? radius_reg[CNT_W-1:0] : half_dim;
    end

    // Derived geometry; the squared radius follows the radius by one register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg  <= DIM_W'(1);
            h_reg  <= DIM_W'(1);
            r_reg  <= '0;
            rr_reg <= '0;
        end
        else
        begin
            w_reg  <= w_eff;
            h_reg  <= h_eff;
            r_reg  <= r_next;
            rr_reg <= SQ_W'(r_reg) * SQ_W'(r_reg);
        end
    end

    assign geom.w  = w_reg;
    assign geom.h  = h_reg;
    assign geom.r  = r_reg;
    assign geom.rr = rr_reg;

    // The clamped radius never exceeds half of either dimension.
    a_radius_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        ({geom.r, 1'b0} <= geom.w) && ({geom.r, 1'b0} <= geom.h))
        else $error("clamped radius exceeds half a frame dimension");

    // The squared radius tracks the radius of the previous cycle.
    a_rr_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> (geom.rr == SQ_W'($past(geom.r)) * SQ_W'($past(geom.r))))
        else $error("squared radius out of step with radius");

endmodule
